// ===== design/assert_macros.svh =====
// assertion macros used by the noise unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MDFN_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MDFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MDFN_ASSERT(lbl, clk, rst_n, prop, msg)
`define MDFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/mdfn_pkg.sv =====
// shared widths and command codes of the multichannel noise filter
`default_nettype none
package mdfn_pkg;
	localparam int PHASE_W  = 16;
	localparam int NOISE_W  = 32;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int CHAN_IN_W = 10;
	localparam int TAP_IN_W  = 8;
	localparam int FRAC_SHIFT = 12;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;
endpackage
`default_nettype wire

// ===== design/mdfn_rem.sv =====
// serial remainder unit, one quotient bit per cycle
`default_nettype none
module mdfn_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mdfn_pkg::PHASE_W-1:0] dividend,
	input  logic [mdfn_pkg::PHASE_W-1:0] divisor,
	output logic                         done,
	output logic [mdfn_pkg::PHASE_W-1:0] remainder
);
	import mdfn_pkg::*;

	localparam int CNT_W = $clog2(PHASE_W);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PHASE_W-1:0] rem_q;
	logic [PHASE_W-1:0] dvd_q;
	logic [PHASE_W-1:0] dsr_q;
	logic [PHASE_W:0]   trial;
	logic               fits;

	assign trial = {rem_q, dvd_q[PHASE_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(PHASE_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// restoring step: remainder stays below the divisor
			rem_q <= fits ? PHASE_W'(trial - {1'b0, dsr_q}) : trial[PHASE_W-1:0];
			dvd_q <= {dvd_q[PHASE_W-2:0], 1'b0};
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ===== design/multichannel_decimated_fir_noise_unit.sv =====
// a load or an out-of-range step passes from accept through dispatch and finish to the result
// a step without update also reads the channel state, waits on the serial remainder of the phase and writes back
// a step with update also runs one multiply-accumulate per tap from memory and drains before writeback
// one item is in work at a time; a finished result waits in the output register
// after reset a clearing pass over max(CHANNELS, TAPS) entries zeroes coefficient and channel memory
// history is not cleared: a per-channel fill count masks samples never written
`default_nettype none
`include "assert_macros.svh"
module multichannel_decimated_fir_noise_unit #(
	parameter int TAPS     = 256,
	parameter int CHANNELS = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 cmd,
	input  logic [mdfn_pkg::CHAN_IN_W-1:0]       channel,
	input  logic [mdfn_pkg::TAP_IN_W-1:0]        tap_index,
	input  logic signed [mdfn_pkg::COEF_W-1:0]   coef_value,
	input  logic signed [mdfn_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mdfn_pkg::NOISE_W-1:0]  noise,
	output logic                                 updated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [mdfn_pkg::PHASE_W-1:0]         cfg_data
);
	import mdfn_pkg::*;

	localparam int TAP_W  = $clog2(TAPS);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int HIST_D = CHANNELS * (2 ** TAP_W);
	localparam int CLR_N  = (CHANNELS > TAPS) ? CHANNELS : TAPS;
	localparam int CLR_W  = $clog2(CLR_N);
	localparam int ACC_W  = (TAP_W + PROD_W + 1 > 44) ? TAP_W + PROD_W + 1 : 44;
	localparam int SH_W   = ACC_W - FRAC_SHIFT;
	localparam logic [TAP_W:0] FILL_MAX = (TAP_W + 1)'(TAPS);
	localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

	typedef struct packed {
		logic [PHASE_W-1:0]        phase;
		logic signed [NOISE_W-1:0] held;
		logic [TAP_W-1:0]          ptr;
		logic [TAP_W:0]            fill;
	} chan_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_CHRD, S_REM, S_MAC, S_DRAIN, S_WB, S_FIN
	} state_t;

	state_t state_q;

	// accepted item
	logic                       cmd_q;
	logic                       step_ok_q;
	logic                       tap_ok_q;
	logic [CH_W-1:0]            ch_q;
	logic [TAP_W-1:0]           tap_q;
	logic signed [COEF_W-1:0]   coef_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [CLR_W-1:0]          clr_q;
	logic [PHASE_W-1:0]        update_interval_q;
	logic                      upd_q;
	logic [TAP_W-1:0]          k_q;
	logic [TAP_W-1:0]          rp_q;
	logic signed [NOISE_W-1:0] res_noise_q;
	logic                      res_upd_q;
	logic                      out_valid_q;
	logic signed [NOISE_W-1:0] noise_q;
	logic                      updated_q;

	// memories
	logic signed [COEF_W-1:0]   coef_mem [TAPS];
	chan_t                      chan_mem [CHANNELS];
	logic signed [SAMPLE_W-1:0] hist_mem [HIST_D];

	logic                       coef_we;
	logic [TAP_W-1:0]           coef_wa;
	logic signed [COEF_W-1:0]   coef_wd;
	logic                       chan_we;
	logic [CH_W-1:0]            chan_wa;
	chan_t                      chan_wd;
	logic                       hist_we;
	chan_t                      chan_rd_q;

	// mac pipeline
	logic signed [COEF_W-1:0]   coef_rd_s1;
	logic signed [SAMPLE_W-1:0] hist_rd_s1;
	logic                       v_s1;
	logic                       zero_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       v_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       mac_start;

	logic signed [SH_W-1:0]     sh;
	logic signed [NOISE_W-1:0]  sat;
	logic [PHASE_W-1:0]         ivl;
	logic                       rem_done;
	logic [PHASE_W-1:0]         rem_val;
	logic                       clr_last;
	logic                       out_free;
	chan_t                      chan_new;

	assign in_ready  = state_q == S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign noise     = noise_q;
	assign updated   = updated_q;

	assign ivl      = (update_interval_q == '0) ? PHASE_W'(1) : update_interval_q;
	assign clr_last = clr_q == CLR_W'(CLR_N - 1);
	assign out_free = !out_valid_q || out_ready;
	assign mac_start = state_q == S_REM && rem_done && rem_val == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			update_interval_q <= PHASE_W'(1);
		end else if (cfg_valid) begin
			update_interval_q <= cfg_data;
		end
	end

	mdfn_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_CHRD),
		.dividend  (chan_rd_q.phase),
		.divisor   (ivl),
		.done      (rem_done),
		.remainder (rem_val)
	);

	// arithmetic shift then saturate to 32 bits
	assign sh = $signed(acc_q[ACC_W-1:FRAC_SHIFT]);
	always_comb begin
		if (64'(sh) > 64'sd2147483647) begin
			sat = {1'b0, {(NOISE_W-1){1'b1}}};
		end else if (64'(sh) < -64'sd2147483648) begin
			sat = {1'b1, {(NOISE_W-1){1'b0}}};
		end else begin
			sat = sh[NOISE_W-1:0];
		end
	end

	always_comb begin
		chan_new       = chan_rd_q;
		chan_new.phase = chan_rd_q.phase + 1'b1;
		if (upd_q) begin
			chan_new.held = sat;
			chan_new.ptr  = (chan_rd_q.ptr == TAP_LAST) ? '0 : chan_rd_q.ptr + 1'b1;
			chan_new.fill = (chan_rd_q.fill == FILL_MAX) ? FILL_MAX : chan_rd_q.fill + 1'b1;
		end
	end

	always_comb begin
		coef_we = 1'b0;
		coef_wa = tap_q;
		coef_wd = coef_q;
		chan_we = 1'b0;
		chan_wa = ch_q;
		chan_wd = chan_new;
		hist_we = 1'b0;
		case (state_q)
			S_CLR: begin
				coef_we = 32'(clr_q) < 32'(TAPS);
				coef_wa = clr_q[TAP_W-1:0];
				coef_wd = '0;
				chan_we = 32'(clr_q) < 32'(CHANNELS);
				chan_wa = clr_q[CH_W-1:0];
				chan_wd = '0;
			end
			S_DISP: begin
				coef_we = cmd_q == CMD_LOAD && tap_ok_q;
			end
			S_WB: begin
				chan_we = 1'b1;
				hist_we = upd_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_wd;
		end
		coef_rd_s1 <= coef_mem[k_q];
	end

	always_ff @(posedge clk) begin
		if (chan_we) begin
			chan_mem[chan_wa] <= chan_wd;
		end
		chan_rd_q <= chan_mem[ch_q];
	end

	// the oldest slot at ptr is overwritten only after all reads of this update
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[{ch_q, chan_rd_q.ptr}] <= sample_q;
		end
		hist_rd_s1 <= hist_mem[{ch_q, rp_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= state_q == S_MAC;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		// samples older than the fill count were never written and count as zero
		zero_s1 <= !({1'b0, k_q} < chan_rd_q.fill);
		if (zero_s1) begin
			prod_s2 <= '0;
		end else begin
			prod_s2 <= coef_rd_s1 * hist_rd_s1;
		end
		if (mac_start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			upd_q       <= 1'b0;
			k_q         <= '0;
			rp_q        <= '0;
			ch_q        <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						step_ok_q <= 32'(channel) < 32'(CHANNELS);
						tap_ok_q  <= 32'(tap_index) < 32'(TAPS);
						ch_q      <= CH_W'(channel);
						tap_q     <= TAP_W'(tap_index);
						coef_q    <= coef_value;
						sample_q  <= sample;
						state_q   <= S_DISP;
					end
				end
				S_DISP: begin
					res_noise_q <= '0;
					res_upd_q   <= 1'b0;
					if (cmd_q == CMD_STEP && step_ok_q) begin
						state_q <= S_CHRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_CHRD: begin
					state_q <= S_REM;
				end
				S_REM: begin
					if (rem_done) begin
						k_q <= '0;
						// newest sample sits just below the write pointer
						rp_q <= (chan_rd_q.ptr == '0) ? TAP_LAST : chan_rd_q.ptr - 1'b1;
						if (rem_val == '0) begin
							upd_q   <= 1'b1;
							state_q <= S_MAC;
						end else begin
							upd_q   <= 1'b0;
							state_q <= S_WB;
						end
					end
				end
				S_MAC: begin
					k_q  <= k_q + 1'b1;
					rp_q <= (rp_q == '0) ? TAP_LAST : rp_q - 1'b1;
					if (k_q == TAP_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					res_noise_q <= chan_new.held;
					res_upd_q   <= upd_q;
					state_q     <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						noise_q     <= res_noise_q;
						updated_q   <= res_upd_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`MDFN_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_FIN, "result appeared outside finish")
	`MDFN_ASSERT_IMP(a_rem_done_in_wait, clk, arst_n, rem_done, state_q == S_REM, "remainder finished outside its wait")
	`MDFN_ASSERT_IMP(a_mac_drained, clk, arst_n, state_q == S_WB && upd_q, !v_s1 && !v_s2, "writeback before mac drained")
	`MDFN_ASSERT_IMP(a_fill_range, clk, arst_n, state_q == S_REM, chan_rd_q.fill <= FILL_MAX, "fill count beyond tap count")
endmodule
`default_nettype wire

// ===== test/multichannel_decimated_fir_noise_unit_tb.sv =====
// self-checking testbench for the multichannel decimated fir noise unit
module multichannel_decimated_fir_noise_unit_tb;
	import mdfn_pkg::*;

	localparam int TAPS            = 256;
	localparam int CHANNELS        = 1024;
	localparam int HOLD_CYCLES     = 400;
	localparam int WATCHDOG_CYCLES = 5000;
	localparam int DRAIN_CYCLES    = 300;
	localparam longint NOISE_MAX   = (longint'(1) <<< (NOISE_W - 1)) - 1;
	localparam longint NOISE_MIN   = -(longint'(1) <<< (NOISE_W - 1));

	typedef struct {
		logic                       cmd;
		logic [CHAN_IN_W-1:0]       ch;
		logic [TAP_IN_W-1:0]        tap;
		logic signed [COEF_W-1:0]   coef;
		logic signed [SAMPLE_W-1:0] smp;
	} noise_cmd_t;

	typedef struct {
		logic signed [NOISE_W-1:0] noise;
		logic                      updated;
	} noise_result_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic                       cmd        = CMD_LOAD;
	logic [CHAN_IN_W-1:0]       channel    = '0;
	logic [TAP_IN_W-1:0]        tap_index  = '0;
	logic signed [COEF_W-1:0]   coef_value = '0;
	logic signed [SAMPLE_W-1:0] sample     = '0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic signed [NOISE_W-1:0]  noise;
	logic                       updated;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [PHASE_W-1:0]         cfg_data   = '0;

	// shadow copy of the filter state, zero after reset
	bit signed [COEF_W-1:0]   coef_mem [TAPS];
	bit signed [SAMPLE_W-1:0] hist_mem [CHANNELS][TAPS];
	bit [PHASE_W-1:0]         phase_mem [CHANNELS];
	bit signed [NOISE_W-1:0]  held_mem [CHANNELS];
	bit [PHASE_W-1:0]         interval_reg = PHASE_W'(1);

	noise_result_t noise_q[$];
	int errors       = 0;
	int quiet_cycles = 0;
	bit idle_on      = 1'b1;
	int stall_req    = 0;
	int stall_ack    = 0;
	int hold_left    = 0;

	multichannel_decimated_fir_noise_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.channel    (channel),
		.tap_index  (tap_index),
		.coef_value (coef_value),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.noise      (noise),
		.updated    (updated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	// expected result of one item, updating the shadow state
	function automatic noise_result_t filter_step(input noise_cmd_t c);
		noise_result_t r;
		longint acc;
		longint shifted;
		bit [PHASE_W-1:0] ivl;
		r.noise = '0;
		r.updated = 1'b0;
		if (c.cmd == CMD_LOAD) begin
			if (int'(c.tap) < TAPS)
				coef_mem[c.tap] = c.coef;
			return r;
		end
		if (int'(c.ch) >= CHANNELS)
			return r;
		ivl = (interval_reg == 0) ? PHASE_W'(1) : interval_reg;
		if (phase_mem[c.ch] % ivl == 0) begin
			acc = 0;
			for (int i = 0; i < TAPS; i++)
				acc += longint'(coef_mem[i]) * longint'(hist_mem[c.ch][TAPS - 1 - i]);
			shifted = acc >>> FRAC_SHIFT;
			if (shifted > NOISE_MAX)
				shifted = NOISE_MAX;
			else if (shifted < NOISE_MIN)
				shifted = NOISE_MIN;
			held_mem[c.ch] = NOISE_W'(shifted);
			for (int i = 0; i < TAPS - 1; i++)
				hist_mem[c.ch][i] = hist_mem[c.ch][i + 1];
			hist_mem[c.ch][TAPS - 1] = c.smp;
			r.updated = 1'b1;
		end
		phase_mem[c.ch] = phase_mem[c.ch] + 1'b1;
		r.noise = held_mem[c.ch];
		return r;
	endfunction

	function automatic noise_cmd_t load_cmd(input int tap, input int coef);
		noise_cmd_t c;
		c.cmd  = CMD_LOAD;
		c.ch   = CHAN_IN_W'($urandom);
		c.smp  = SAMPLE_W'($urandom);
		c.tap  = TAP_IN_W'(tap);
		c.coef = COEF_W'(coef);
		return c;
	endfunction

	function automatic noise_cmd_t step_cmd(input int ch, input int smp);
		noise_cmd_t c;
		c.cmd  = CMD_STEP;
		c.tap  = TAP_IN_W'($urandom);
		c.coef = COEF_W'($urandom);
		c.ch   = CHAN_IN_W'(ch);
		c.smp  = SAMPLE_W'(smp);
		return c;
	endfunction

	// mostly steps on a few busy channels so their history fills up
	function automatic noise_cmd_t random_item();
		int pick;
		int ch;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			return load_cmd($urandom_range(0, TAPS - 1), $urandom);
		if (pick < 75) begin
			ch = $urandom_range(0, 3);
			if (ch == 3)
				ch = CHANNELS - 1;
		end else begin
			ch = $urandom_range(0, CHANNELS - 1);
		end
		return step_cmd(ch, $urandom);
	endfunction

	task automatic send_item(input noise_cmd_t c);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c.cmd;
		channel    <= c.ch;
		tap_index  <= c.tap;
		coef_value <= c.coef;
		sample     <= c.smp;
		do begin
			@(posedge clk);
		end while (!in_ready);
		noise_q.push_back(filter_step(c));
	endtask

	task automatic wait_all_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (noise_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_interval(input int value);
		wait_all_results();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= PHASE_W'(value);
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		interval_reg = PHASE_W'(value);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed();
		send_item(load_cmd(0, 131071));
		send_item(load_cmd(TAPS - 1, -131072));
		send_item(load_cmd(1, -1));
		send_item(load_cmd(TAPS - 2, 1));
		send_item(load_cmd(2, 'h15555));
		send_item(load_cmd(3, -'h15556));
		send_item(step_cmd(0, 32767));
		send_item(step_cmd(0, -32768));
		send_item(step_cmd(0, -1));
		send_item(step_cmd(0, 0));
		send_item(step_cmd(0, 'h5555));
		send_item(step_cmd(CHANNELS - 1, -32768));
		send_item(step_cmd(CHANNELS - 1, 32767));
		send_item(step_cmd(CHANNELS - 1, -'h5556));
		send_item(step_cmd(CHANNELS - 1, 1));
		send_item(load_cmd(0, 0));
		send_item(step_cmd(0, 100));
		send_item(step_cmd(CHANNELS - 1, -100));
	endtask

	task automatic test_interval_settings();
		// zero interval behaves like one
		write_interval(0);
		repeat (3) send_item(step_cmd(7, $urandom));
		send_item(load_cmd(4, $urandom));
		write_interval(3);
		repeat (7) send_item(step_cmd(7, $urandom));
		write_interval(16'hffff);
		repeat (3) send_item(step_cmd(8, $urandom));
		write_interval(1);
		repeat (2) send_item(step_cmd(8, $urandom));
	endtask

	task automatic test_backpressure();
		// receiver holds off while items keep coming, then the sender drains
		stall_req++;
		repeat (12) send_item(random_item());
		wait_all_results();
	endtask

	task automatic test_random();
		write_interval(1);
		repeat (130) send_item(random_item());
		write_interval($urandom_range(2, 4));
		idle_on = 1'b0;
		repeat (130) send_item(random_item());
		idle_on = 1'b1;
		write_interval($urandom_range(1, 8));
		repeat (130) send_item(random_item());
	endtask

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (stall_ack != stall_req) begin
			stall_ack = stall_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(0, 99) < 16);
		end
	end

	always @(posedge clk) begin
		noise_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (noise_q.size() == 0) begin
				$display("%0t: unexpected item: noise %0d updated %0b", $time, noise, updated);
				errors++;
			end else begin
				want = noise_q.pop_front();
				if (noise !== want.noise) begin
					$display("%0t: noise mismatch: expected %0d, actual %0d",
						$time, want.noise, noise);
					errors++;
				end
				if (updated !== want.updated) begin
					$display("%0t: updated mismatch: expected %0b, actual %0b",
						$time, want.updated, updated);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_interval_settings();
		test_backpressure();
		test_random();
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (noise_q.size() != 0) begin
			$display("%0t: %0d expected items never arrived", $time, noise_q.size());
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ===== multichannel_decimated_fir_noise_unit.f =====
+incdir+design
design/mdfn_pkg.sv
design/mdfn_rem.sv
design/multichannel_decimated_fir_noise_unit.sv
test/multichannel_decimated_fir_noise_unit_tb.sv
